// ----- design/mqtr_pkg.sv -----
// mqtr_pkg: shared types, constants and the 5x5 font of the marquee column renderer
// depends on nothing; used by mqtr_glyph and marquee_text_column_renderer_top
`default_nettype none

package mqtr_pkg;

    localparam int DISPLAY_WIDTH_DEF = 128;
    localparam int TEXT_CAPACITY_DEF = 255;

    localparam int CHAR_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int SCROLL_W = 11;
    localparam int LEFT_W   = 7;
    localparam int COL_W    = 7;
    localparam int BITS_W   = 5;

    localparam logic [LEFT_W-1:0] TEXT_LEFT_RST = 7'd4;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 7'h20;

    // item kinds
    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_CHAR   = 3'd2,
        REQ_QUERY  = 3'd3,
        REQ_FRAME  = 3'd4
    } req_t;

    // one character slot hit by a query
    typedef struct packed {
        logic       hit;
        logic [2:0] k;
    } tap_t;

    // rows of a glyph, index 0 is the top row, bit 4 is the leftmost column
    typedef logic [0:4][4:0] glyph_t;

    function automatic glyph_t font_rows(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] uc;
        glyph_t            rows;
        uc = (ch inside {[7'h61:7'h7A]}) ? ch - 7'h20 : ch;
        case (uc)
            7'h41: rows = {5'd14, 5'd17, 5'd31, 5'd17, 5'd17};
            7'h42: rows = {5'd30, 5'd17, 5'd30, 5'd17, 5'd30};
            7'h43: rows = {5'd15, 5'd16, 5'd16, 5'd16, 5'd15};
            7'h44: rows = {5'd30, 5'd17, 5'd17, 5'd17, 5'd30};
            7'h45: rows = {5'd31, 5'd16, 5'd30, 5'd16, 5'd31};
            7'h46: rows = {5'd31, 5'd16, 5'd30, 5'd16, 5'd16};
            7'h47: rows = {5'd15, 5'd16, 5'd23, 5'd17, 5'd15};
            7'h48: rows = {5'd17, 5'd17, 5'd31, 5'd17, 5'd17};
            7'h49: rows = {5'd31, 5'd4,  5'd4,  5'd4,  5'd31};
            7'h4A: rows = {5'd7,  5'd2,  5'd2,  5'd18, 5'd12};
            7'h4B: rows = {5'd17, 5'd18, 5'd28, 5'd18, 5'd17};
            7'h4C: rows = {5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            7'h4D: rows = {5'd17, 5'd27, 5'd21, 5'd17, 5'd17};
            7'h4E: rows = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17};
            7'h4F: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd14};
            7'h50: rows = {5'd30, 5'd17, 5'd30, 5'd16, 5'd16};
            7'h51: rows = {5'd14, 5'd17, 5'd21, 5'd19, 5'd15};
            7'h52: rows = {5'd30, 5'd17, 5'd30, 5'd18, 5'd17};
            7'h53: rows = {5'd15, 5'd16, 5'd14, 5'd1,  5'd30};
            7'h54: rows = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4};
            7'h55: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            7'h56: rows = {5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            7'h57: rows = {5'd17, 5'd17, 5'd21, 5'd27, 5'd17};
            7'h58: rows = {5'd17, 5'd10, 5'd4,  5'd10, 5'd17};
            7'h59: rows = {5'd17, 5'd10, 5'd4,  5'd4,  5'd4};
            7'h5A: rows = {5'd31, 5'd2,  5'd4,  5'd8,  5'd31};
            7'h30: rows = {5'd14, 5'd17, 5'd19, 5'd21, 5'd14};
            7'h31: rows = {5'd4,  5'd12, 5'd4,  5'd4,  5'd14};
            7'h32: rows = {5'd14, 5'd1,  5'd6,  5'd8,  5'd31};
            7'h33: rows = {5'd30, 5'd1,  5'd6,  5'd1,  5'd30};
            7'h34: rows = {5'd18, 5'd18, 5'd31, 5'd2,  5'd2};
            7'h35: rows = {5'd31, 5'd16, 5'd30, 5'd1,  5'd30};
            7'h36: rows = {5'd14, 5'd16, 5'd30, 5'd17, 5'd14};
            7'h37: rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd4};
            7'h38: rows = {5'd14, 5'd17, 5'd14, 5'd17, 5'd14};
            7'h39: rows = {5'd14, 5'd17, 5'd15, 5'd1,  5'd14};
            7'h2D: rows = {5'd0,  5'd0,  5'd14, 5'd0,  5'd0};   // minus
            7'h2E: rows = {5'd0,  5'd0,  5'd0,  5'd0,  5'd4};   // period
            7'h2C: rows = {5'd0,  5'd0,  5'd0,  5'd0,  5'd6};   // comma
            7'h21: rows = {5'd4,  5'd4,  5'd4,  5'd4,  5'd0};   // exclamation
            7'h3A: rows = {5'd0,  5'd4,  5'd0,  5'd4,  5'd0};   // colon
            7'h3F: rows = {5'd14, 5'd1,  5'd6,  5'd0,  5'd4};   // question
            7'h2F: rows = {5'd16, 5'd8,  5'd4,  5'd2,  5'd1};   // slash
            default: rows = '0;
        endcase
        return rows;
    endfunction

    // vertical column k of a glyph, bit 0 is the top row
    function automatic logic [BITS_W-1:0] glyph_column(input logic [CHAR_W-1:0] ch,
                                                       input logic [2:0] k);
        glyph_t              rows;
        logic [2:0]          idx;
        logic [BITS_W-1:0]   bits;
        rows = font_rows(ch);
        idx  = 3'd4 - k;
        for (int r = 0; r < BITS_W; r++) begin
            bits[r] = rows[r][idx];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ----- design/mqtr_glyph.sv -----
// mqtr_glyph: turns the two character taps of a query into lit pixels
// depends on mqtr_pkg (tap_t, glyph_column)
`default_nettype none

module mqtr_glyph (
    input  wire mqtr_pkg::tap_t                     tap0,
    input  wire mqtr_pkg::tap_t                     tap1,
    input  wire logic [mqtr_pkg::CHAR_W-1:0]        ch0,
    input  wire logic [mqtr_pkg::CHAR_W-1:0]        ch1,
    output logic [mqtr_pkg::BITS_W-1:0]             bits
);
    import mqtr_pkg::*;

    logic [BITS_W-1:0] bits0;
    logic [BITS_W-1:0] bits1;

    always_comb
    begin
        bits0 = tap0.hit ? glyph_column(ch0, tap0.k) : '0;
        bits1 = tap1.hit ? glyph_column(ch1, tap1.k) : '0;
        bits  = bits0 | bits1;
    end

endmodule

`default_nettype wire

// ----- design/marquee_text_column_renderer_top.sv -----
// marquee_text_column_renderer_top: text store, scroll state and query pipeline
// depends on mqtr_pkg and mqtr_glyph
`default_nettype none

// Marquee text column renderer. Holds one line of up to TEXT_CAPACITY printable
// characters and a scroll offset, and answers which of the 5 text rows are lit at a
// display column. Every item on s_axis gives exactly one result on m_axis. The block
// takes one item per clock unless back-pressure on the result side stalls the whole
// pipeline of input register, text memory read stage and result register. All state
// updates happen in the memory read stage in item order, so a query always sees every
// earlier append. text_left is to be written through cfg only while the block is idle;
// the block itself does not enforce this. Its reset value is 4. The text memory has no
// reset: only entries below the character count are ever drawn.
module marquee_text_column_renderer_top #(
    parameter int DISPLAY_WIDTH = mqtr_pkg::DISPLAY_WIDTH_DEF,
    parameter int TEXT_CAPACITY = mqtr_pkg::TEXT_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: text_left
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,      // text_left
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // char_code [7:0], column [14:8], zero [15]
    input  wire logic [2:0]  s_tuser,       // req_type [2:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata        // column_bits [4:0], text_length [12:5],
                                            // scroll_offset [23:13]
);
    import mqtr_pkg::*;

    localparam int AW = (TEXT_CAPACITY > 1) ? $clog2(TEXT_CAPACITY) : 1;
    localparam int SW = 13;   // signed width for column arithmetic
    localparam logic signed [SW-1:0] WIDTH_S = SW'(DISPLAY_WIDTH);
    localparam logic [COUNT_W:0]     CAP     = (COUNT_W+1)'(TEXT_CAPACITY);

    // configuration register, always ready
    logic [LEFT_W-1:0] text_left_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_left_reg <= TEXT_LEFT_RST;
        else if (cfg_valid)
            text_left_reg <= cfg_data;
    end

    // pipeline handshake
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_adv;
    logic s1_free;
    logic s0_adv;
    logic s_acc;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign s0_adv   = s0_valid_reg && s1_free;
    assign s_tready = !s0_valid_reg || s0_adv;
    assign s_acc    = s_tvalid && s_tready;

    // input register
    req_t              s0_req_reg;
    logic [7:0]        s0_char_reg;
    logic [COL_W-1:0]  s0_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_tready)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s0_req_reg  <= req_t'(s_tuser);
            s0_char_reg <= s_tdata[7:0];
            s0_col_reg  <= s_tdata[14:8];
        end
    end

    // text state
    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic [SCROLL_W-1:0] scroll_reg, scroll_next;
    logic                wr_en;
    logic [CHAR_W-1:0]   wr_char;

    // geometry of the current text
    logic [SCROLL_W-1:0]   tpx;        // 6 * length
    logic [SCROLL_W-1:0]   cyc;        // scroll cycle length
    logic signed [SW-1:0]  vis;
    logic                  narrow;
    logic                  fits;
    logic                  active;
    logic signed [SW-1:0]  col_s;
    logic signed [SW-1:0]  left_s;
    logic signed [SW-1:0]  e0;
    logic signed [SW-1:0]  e1;
    logic [SCROLL_W:0]     step;

    always_comb
    begin
        tpx    = SCROLL_W'({count_reg, 2'b00}) + SCROLL_W'({count_reg, 1'b0});
        cyc    = tpx + SCROLL_W'(12);
        left_s = SW'(text_left_reg);
        col_s  = SW'(s0_col_reg);
        vis    = WIDTH_S - left_s;
        narrow = vis <= SW'(5);
        fits   = $signed(SW'(tpx)) <= vis;
        active = (count_reg != '0) && !narrow && (col_s < WIDTH_S);
        // static text starts at text_left, scrolling copies at width - offset
        e0     = fits ? col_s - left_s : col_s + SW'(scroll_reg) - WIDTH_S;
        e1     = e0 - SW'(cyc);
        step   = (SCROLL_W+1)'(scroll_reg) + (SCROLL_W+1)'(1);
    end

    // split a column offset into character index and pixel column
    function automatic logic [COUNT_W-1:0] div6(input logic [SCROLL_W-1:0] e);
        logic [SCROLL_W+11:0] prod;
        prod = (SCROLL_W+12)'(e) * (SCROLL_W+12)'(2731);
        return prod[COUNT_W+13:14];
    endfunction

    logic [COUNT_W-1:0] idx0, idx1;
    logic [2:0]         k0, k1;
    tap_t               tap0, tap1;
    logic               is_query;

    always_comb
    begin
        is_query = s0_req_reg == REQ_QUERY;
        idx0     = div6(e0[SCROLL_W-1:0]);
        idx1     = div6(e1[SCROLL_W-1:0]);
        k0       = 3'(e0[SCROLL_W-1:0] - (SCROLL_W'({idx0, 2'b00}) + SCROLL_W'({idx0, 1'b0})));
        k1       = 3'(e1[SCROLL_W-1:0] - (SCROLL_W'({idx1, 2'b00}) + SCROLL_W'({idx1, 1'b0})));
        // drawn whole once its start + 5 reaches text_left: start = col - k
        tap0.hit = is_query && active && (e0 >= 0) && (e0 < SW'(tpx)) && (k0 < 3'd5)
                   && (col_s + SW'(5) - SW'(k0) >= left_s);
        tap0.k   = k0;
        tap1.hit = is_query && active && !fits && (e1 >= 0) && (e1 < SW'(tpx))
                   && (k1 < 3'd5) && (col_s + SW'(5) - SW'(k1) >= left_s);
        tap1.k   = k1;
    end

    // item effect on the text state
    always_comb
    begin
        count_next  = count_reg;
        scroll_next = scroll_reg;
        wr_en       = 1'b0;
        wr_char     = CHAR_SPACE;
        case (s0_req_reg)
            REQ_CLEAR:
            begin
                count_next  = '0;
                scroll_next = '0;
            end
            REQ_APPEND:
            begin
                if (count_reg != '0 && (COUNT_W+1)'(count_reg) < CAP)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            REQ_CHAR:
            begin
                if ((s0_char_reg inside {[8'h20:8'h7E]}) && (COUNT_W+1)'(count_reg) < CAP)
                begin
                    wr_en      = 1'b1;
                    wr_char    = s0_char_reg[CHAR_W-1:0];
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            REQ_FRAME:
            begin
                if (count_reg != '0 && !narrow)
                begin
                    if (fits)
                        scroll_next = '0;
                    else if (step >= (SCROLL_W+1)'(cyc))
                        scroll_next = SCROLL_W'(step - (SCROLL_W+1)'(cyc));
                    else
                        scroll_next = SCROLL_W'(step);
                end
            end
            default:
            begin
                count_next  = count_reg;
                scroll_next = scroll_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scroll_reg <= '0;
        end
        else if (s0_adv)
        begin
            count_reg  <= count_next;
            scroll_reg <= scroll_next;
        end
    end

    // text memory, one write and two registered reads
    logic [CHAR_W-1:0] text_mem [TEXT_CAPACITY];
    logic [CHAR_W-1:0] rd0_reg, rd1_reg;

    always_ff @(posedge clk)
    begin
        if (s0_adv && wr_en)
            text_mem[count_reg[AW-1:0]] <= wr_char;
        if (s0_adv)
        begin
            rd0_reg <= text_mem[idx0[AW-1:0]];
            rd1_reg <= text_mem[idx1[AW-1:0]];
        end
    end

    // memory read stage
    tap_t                s1_tap0_reg, s1_tap1_reg;
    logic [COUNT_W-1:0]  s1_len_reg;
    logic [SCROLL_W-1:0] s1_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            s1_tap0_reg <= tap0;
            s1_tap1_reg <= tap1;
            s1_len_reg  <= count_next;
            s1_pos_reg  <= scroll_next;
        end
    end

    // glyph lookup and result register
    logic [BITS_W-1:0]   col_bits;
    logic [BITS_W-1:0]   out_bits_reg;
    logic [COUNT_W-1:0]  out_len_reg;
    logic [SCROLL_W-1:0] out_pos_reg;

    mqtr_glyph u_glyph (
        .tap0 (s1_tap0_reg),
        .tap1 (s1_tap1_reg),
        .ch0  (rd0_reg),
        .ch1  (rd1_reg),
        .bits (col_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_bits_reg <= col_bits;
            out_len_reg  <= s1_len_reg;
            out_pos_reg  <= s1_pos_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_len_reg, out_bits_reg};

    // the offset never reaches the cycle length of the stored text
    a_scroll_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        scroll_reg < cyc)
        else $error("scroll offset outside cycle");

    // an empty text keeps the offset at zero
    a_empty_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> scroll_reg == '0)
        else $error("offset set with empty text");

    // the count grows by one or drops to zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + COUNT_W'(1)) || (count_reg == '0))
        else $error("count jumped");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (COUNT_W+1)'(count_reg) <= CAP)
        else $error("count over capacity");

    // a stalled read stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_len_reg)
                                    && $stable(s1_pos_reg))
        else $error("read stage lost a stalled item");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for marquee_text_column_renderer_top: directed rows, a capacity fill, a wrap run
// and random sessions, checked item by item against typed-in rows or a built-in column predictor
// depends on mqtr_pkg and the design sources
`timescale 1ns / 100ps

module testbench;
    import mqtr_pkg::*;

    // drawing geometry of the marquee
    localparam int PITCH   = 6;
    localparam int GAP     = 12;
    localparam int GLYPH_W = 5;

    // request codes with no meaning to the block
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int IDLE_LIMIT       = 2000;
    localparam int DRAIN_TAIL       = 16;
    localparam int RANDOM_ITEMS     = 600;
    localparam int PRINT_CAP        = 40;
    localparam int CAP_SCROLL_STEPS = 40;
    localparam int WRAP_CHARS       = 24;

    // the seven drawn punctuation marks
    localparam logic [55:0] MARK_BYTES = "-.,!:?/";

    typedef struct packed {
        logic [4:0]  bits;
        logic [7:0]  length;
        logic [10:0] offset;
    } column_result_t;

    typedef struct packed {
        logic [2:0]     req;
        logic [7:0]     ch;
        logic [6:0]     col;
        logic           fixed;
        column_result_t result;
    } stim_row_t;

    // directed rows, run right after reset with text_left at its reset value 4
    // fixed rows carry a typed-in result, the rest go through the predictor
    localparam stim_row_t DIRECTED_STEPS [0:24] = '{
        '{REQ_QUERY,    8'h00, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},  // empty text draws nothing
        '{REQ_FRAME,    8'h00, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},  // frame on empty text
        '{REQ_APPEND,   8'h00, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},  // no leading space
        '{REQ_CHAR,     8'h1F, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},  // below printable range
        '{REQ_CHAR,     8'h7F, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},  // above printable range
        '{REQ_CHAR,     8'hFF, 7'd127, 1'b1, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CHAR,     8'h80, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CHAR,     8'h61, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},  // lower case folds up
        '{REQ_CHAR,     8'h5A, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CHAR,     8'h30, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CHAR,     8'h2F, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_APPEND,   8'h00, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CHAR,     8'h7E, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},  // printable but blank
        '{REQ_CHAR,     8'h20, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CHAR,     8'h3F, 7'd0,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_QUERY,    8'h00, 7'd3,   1'b1, '{5'd0, 8'd8, 11'd0}},  // left of the text area
        '{REQ_QUERY,    8'h00, 7'd4,   1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_QUERY,    8'h00, 7'd9,   1'b0, '{5'd0, 8'd0, 11'd0}},  // gap column
        '{REQ_QUERY,    8'h00, 7'd127, 1'b1, '{5'd0, 8'd8, 11'd0}},  // past the static text
        '{REQ_FRAME,    8'h00, 7'd0,   1'b1, '{5'd0, 8'd8, 11'd0}},  // fitting text stays put
        '{REQ_SPARE_LO, 8'hFF, 7'd127, 1'b1, '{5'd0, 8'd8, 11'd0}},
        '{REQ_SPARE_HI, 8'h41, 7'd5,   1'b1, '{5'd0, 8'd8, 11'd0}},
        '{REQ_QUERY,    8'h00, 7'd20,  1'b0, '{5'd0, 8'd0, 11'd0}},
        '{REQ_CLEAR,    8'h00, 7'd0,   1'b1, '{5'd0, 8'd0, 11'd0}},
        '{REQ_QUERY,    8'h00, 7'd4,   1'b1, '{5'd0, 8'd0, 11'd0}}   // nothing after clear
    };

    // text_left settings walked by the random part, largest first
    localparam logic [6:0] LEFT_PICKS [0:4] = '{7'd127, 7'd123, 7'd122, 7'd4, 7'd0};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // char_code [7:0], column [14:8], zero [15]
    logic [2:0]  s_tuser;   // req_type [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // column_bits [4:0], text_length [12:5], scroll_offset [23:13]

    marquee_text_column_renderer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor copy of the block state
    logic [6:0]  text_chars [0:TEXT_CAPACITY_DEF-1];
    logic [7:0]  char_count = '0;
    logic [10:0] scroll_px  = '0;
    logic [6:0]  area_left  = TEXT_LEFT_RST;

    // expected results in item order
    column_result_t expected_results [$];

    int errors          = 0;
    int items_sent      = 0;
    int random_items    = 0;
    int results_checked = 0;
    int configs_written = 0;
    int peak_offset     = 0;
    int peak_length     = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    bit steady_sender   = 1'b0;
    bit counting        = 1'b0;

    // font rows, row 0 in the top five bits, bit 4 of a row is the leftmost column
    function automatic logic [24:0] letter_font(input int idx);
        case (idx)
            0:  return {5'd14, 5'd17, 5'd31, 5'd17, 5'd17};
            1:  return {5'd30, 5'd17, 5'd30, 5'd17, 5'd30};
            2:  return {5'd15, 5'd16, 5'd16, 5'd16, 5'd15};
            3:  return {5'd30, 5'd17, 5'd17, 5'd17, 5'd30};
            4:  return {5'd31, 5'd16, 5'd30, 5'd16, 5'd31};
            5:  return {5'd31, 5'd16, 5'd30, 5'd16, 5'd16};
            6:  return {5'd15, 5'd16, 5'd23, 5'd17, 5'd15};
            7:  return {5'd17, 5'd17, 5'd31, 5'd17, 5'd17};
            8:  return {5'd31, 5'd4,  5'd4,  5'd4,  5'd31};
            9:  return {5'd7,  5'd2,  5'd2,  5'd18, 5'd12};
            10: return {5'd17, 5'd18, 5'd28, 5'd18, 5'd17};
            11: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            12: return {5'd17, 5'd27, 5'd21, 5'd17, 5'd17};
            13: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17};
            14: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd14};
            15: return {5'd30, 5'd17, 5'd30, 5'd16, 5'd16};
            16: return {5'd14, 5'd17, 5'd21, 5'd19, 5'd15};
            17: return {5'd30, 5'd17, 5'd30, 5'd18, 5'd17};
            18: return {5'd15, 5'd16, 5'd14, 5'd1,  5'd30};
            19: return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4};
            20: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            21: return {5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            22: return {5'd17, 5'd17, 5'd21, 5'd27, 5'd17};
            23: return {5'd17, 5'd10, 5'd4,  5'd10, 5'd17};
            24: return {5'd17, 5'd10, 5'd4,  5'd4,  5'd4};
            default: return {5'd31, 5'd2,  5'd4,  5'd8,  5'd31};
        endcase
    endfunction

    function automatic logic [24:0] digit_font(input int idx);
        case (idx)
            0: return {5'd14, 5'd17, 5'd19, 5'd21, 5'd14};
            1: return {5'd4,  5'd12, 5'd4,  5'd4,  5'd14};
            2: return {5'd14, 5'd1,  5'd6,  5'd8,  5'd31};
            3: return {5'd30, 5'd1,  5'd6,  5'd1,  5'd30};
            4: return {5'd18, 5'd18, 5'd31, 5'd2,  5'd2};
            5: return {5'd31, 5'd16, 5'd30, 5'd1,  5'd30};
            6: return {5'd14, 5'd16, 5'd30, 5'd17, 5'd14};
            7: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd4};
            8: return {5'd14, 5'd17, 5'd14, 5'd17, 5'd14};
            default: return {5'd14, 5'd17, 5'd15, 5'd1,  5'd14};
        endcase
    endfunction

    function automatic logic [24:0] glyph_bitmap(input logic [6:0] ch);
        logic [6:0] up;
        up = (ch >= 7'h61 && ch <= 7'h7A) ? ch - 7'h20 : ch;
        if (up >= 7'h41 && up <= 7'h5A)
            return letter_font(int'(up) - 'h41);
        if (up >= 7'h30 && up <= 7'h39)
            return digit_font(int'(up) - 'h30);
        case (up)
            7'h2D: return {5'd0,  5'd0, 5'd14, 5'd0, 5'd0};
            7'h2E: return {5'd0,  5'd0, 5'd0,  5'd0, 5'd4};
            7'h2C: return {5'd0,  5'd0, 5'd0,  5'd0, 5'd6};
            7'h21: return {5'd4,  5'd4, 5'd4,  5'd4, 5'd0};
            7'h3A: return {5'd0,  5'd4, 5'd0,  5'd4, 5'd0};
            7'h3F: return {5'd14, 5'd1, 5'd6,  5'd0, 5'd4};
            7'h2F: return {5'd16, 5'd8, 5'd4,  5'd2, 5'd1};
            default: return '0;
        endcase
    endfunction

    // pixel column k of a glyph, bit 0 is the top row
    function automatic logic [4:0] glyph_slice(input logic [6:0] ch, input int k);
        logic [24:0] rows;
        logic [4:0]  bits;
        rows = glyph_bitmap(ch);
        for (int r = 0; r < 5; r++)
            bits[r] = rows[24 - 5 * r - k];
        return bits;
    endfunction

    function automatic logic [4:0] lit_pixels(input logic [6:0] col);
        int         vis;
        int         len;
        int         c;
        int         tpx;
        int         span;
        int         base;
        int         e;
        int         slot;
        int         k;
        logic [4:0] bits;
        vis  = DISPLAY_WIDTH_DEF - int'(area_left);
        len  = int'(char_count);
        c    = int'(col);
        bits = '0;
        if (len == 0 || vis <= GLYPH_W || c >= DISPLAY_WIDTH_DEF)
            return '0;
        tpx = PITCH * len;
        // fitting text is drawn once from text_left
        if (tpx <= vis)
        begin
            e = c - int'(area_left);
            if (e >= 0 && e / PITCH < len && e % PITCH < GLYPH_W)
                bits = glyph_slice(text_chars[e / PITCH], e % PITCH);
            return bits;
        end
        // two scrolling copies one text-plus-gap span apart, glyphs ending left of text_left dropped
        span = tpx + GAP;
        for (int n = 0; n < 2; n++)
        begin
            base = DISPLAY_WIDTH_DEF - int'(scroll_px) + n * span;
            e    = c - base;
            if (e >= 0)
            begin
                slot = e / PITCH;
                k    = e % PITCH;
                if (slot < len && k < GLYPH_W && base + PITCH * slot + GLYPH_W >= int'(area_left))
                    bits |= glyph_slice(text_chars[slot], k);
            end
        end
        return bits;
    endfunction

    // applies one item to the predictor state and returns its result
    function automatic column_result_t predict_item(input logic [2:0] req, input logic [7:0] ch,
                                                    input logic [6:0] col);
        column_result_t res;
        int             tpx;
        res = '0;
        case (req)
            REQ_CLEAR:
            begin
                char_count = '0;
                scroll_px  = '0;
            end
            REQ_APPEND:
            begin
                if (char_count > 0 && char_count < TEXT_CAPACITY_DEF)
                begin
                    text_chars[char_count] = CHAR_SPACE;
                    char_count++;
                end
            end
            REQ_CHAR:
            begin
                if (ch >= 8'h20 && ch <= 8'h7E && char_count < TEXT_CAPACITY_DEF)
                begin
                    text_chars[char_count] = ch[6:0];
                    char_count++;
                end
            end
            REQ_QUERY:
                res.bits = lit_pixels(col);
            REQ_FRAME:
            begin
                // empty text or a narrow area leaves the offset alone
                if (char_count != 0 && DISPLAY_WIDTH_DEF > int'(area_left) + GLYPH_W)
                begin
                    tpx = PITCH * int'(char_count);
                    if (tpx <= DISPLAY_WIDTH_DEF - int'(area_left))
                        scroll_px = '0;
                    else
                        scroll_px = 11'((int'(scroll_px) + 1) % (tpx + GAP));
                end
            end
            default:
            begin
            end
        endcase
        res.length = char_count;
        res.offset = scroll_px;
        return res;
    endfunction

    function automatic logic [7:0] printable_pick();
        int r;
        int idx;
        r   = $urandom_range(0, 9);
        idx = $urandom_range(0, 6);
        case (r)
            0, 1, 2: return 8'(8'h41 + $urandom_range(0, 25));
            3, 4:    return 8'(8'h61 + $urandom_range(0, 25));
            5, 6:    return 8'(8'h30 + $urandom_range(0, 9));
            7:       return MARK_BYTES[8 * idx +: 8];
            8:       return 8'h20;
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t ns: %0s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // drives one item; called at a falling edge, returns at the falling edge after acceptance
    // with tvalid still high so that a following item can go out with no gap in tvalid
    task automatic send_item(input logic [2:0] req, input logic [7:0] ch, input logic [6:0] col,
                             input logic fixed, input column_result_t fixed_result);
        column_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_left   = steady_sender ? 0 : $urandom_range(0, 5);
        end
        while (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left--;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, col, ch};
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_item(req, ch, col);
        expected_results.push_back(fixed ? fixed_result : predicted);
        items_sent++;
        // non-printable character bytes and spare codes do not count toward the random total
        if (counting && req <= REQ_FRAME &&
            !(req == REQ_CHAR && (ch < 8'h20 || ch > 8'h7E)))
            random_items++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send(input logic [2:0] req, input logic [7:0] ch, input logic [6:0] col);
        send_item(req, ch, col, 1'b0, '0);
    endtask

    // holds the sender off until every expected result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_text_left(input logic [6:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        area_left = value;
        configs_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one marquee session: new text, then a mix of frames and queries
    task automatic run_session();
        int text_len;
        int steps;
        int r;
        if ($urandom_range(0, 9) != 0)
            send(REQ_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        r        = $urandom_range(0, 19);
        text_len = (r == 0) ? $urandom_range(120, 255) :
                   (r < 4)  ? $urandom_range(20, 60)   : $urandom_range(1, 24);
        for (int i = 0; i < text_len; i++)
        begin
            r = $urandom_range(0, 15);
            if (r < 2)
                send(REQ_APPEND, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            else if (r == 2)
                send(REQ_CHAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            else
                send(REQ_CHAR, printable_pick(), 7'($urandom_range(0, 127)));
        end
        steps = $urandom_range(10, 160);
        for (int i = 0; i < steps; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send(REQ_FRAME, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            else if (r < 90)
                send(REQ_QUERY, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            else if (r < 94)
                send(REQ_CHAR, printable_pick(), 7'($urandom_range(0, 127)));  // grows mid-scroll
            else if (r < 96)
                send(REQ_APPEND, 8'h00, 7'($urandom_range(0, 127)));
            else if (r < 98)
                send(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                     8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            else
                send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 7) == 0)
            wait_for_results();
    endtask

    // receiver ready: all-ready stretches, a rotating 32-bit pattern, or random draws ready three times in four
    int          rx_cycle   = 0;
    int          rx_mode    = 0;
    logic [31:0] rx_pattern = '1;

    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 300 == 0)
        begin
            rx_mode    = $urandom_range(0, 2);
            rx_pattern = $urandom | 32'h1;
        end
        m_tready <= (rx_mode == 0) ? 1'b1 :
                    (rx_mode == 1) ? rx_pattern[rx_cycle % 32] : ($urandom_range(0, 3) != 0);
    end

    // result checker, oldest expectation first
    always @(posedge clk)
    begin
        column_result_t got;
        column_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.bits   = m_tdata[4:0];
            got.length = m_tdata[12:5];
            got.offset = m_tdata[23:13];
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected, raw", int'(m_tdata), 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.bits !== want.bits)
                    report_mismatch("column_bits", int'(got.bits), int'(want.bits));
                if (got.length !== want.length)
                    report_mismatch("text_length", int'(got.length), int'(want.length));
                if (got.offset !== want.offset)
                    report_mismatch("scroll_offset", int'(got.offset), int'(want.offset));
                results_checked++;
                if (int'(want.offset) > peak_offset)
                    peak_offset = int'(want.offset);
                if (int'(want.length) > peak_length)
                    peak_length = int'(want.length);
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int session;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows at the reset value of text_left
        foreach (DIRECTED_STEPS[i])
            send_item(DIRECTED_STEPS[i].req, DIRECTED_STEPS[i].ch, DIRECTED_STEPS[i].col,
                      DIRECTED_STEPS[i].fixed, DIRECTED_STEPS[i].result);
        wait_for_results();

        // fill past capacity on the widest area, then scroll the full text a little
        write_text_left(7'd0);
        send(REQ_CLEAR, 8'h00, 7'd0);
        for (int i = 0; i < TEXT_CAPACITY_DEF + 5; i++)
            send(REQ_CHAR, printable_pick(), 7'($urandom_range(0, 127)));
        send(REQ_APPEND, 8'h00, 7'd0);
        for (int i = 0; i < CAP_SCROLL_STEPS; i++)
        begin
            send(REQ_FRAME, 8'h00, 7'd0);
            if ($urandom_range(0, 5) == 0)
                send(REQ_QUERY, 8'h00, 7'($urandom_range(0, 127)));
        end

        // a shorter scrolling text taken through a whole cycle and past the wrap
        send(REQ_CLEAR, 8'h00, 7'd0);
        for (int i = 0; i < WRAP_CHARS; i++)
            send(REQ_CHAR, printable_pick(), 7'($urandom_range(0, 127)));
        for (int i = 0; i < PITCH * WRAP_CHARS + GAP + 4; i++)
        begin
            send(REQ_FRAME, 8'h00, 7'd0);
            if ($urandom_range(0, 5) == 0)
                send(REQ_QUERY, 8'h00, 7'($urandom_range(0, 127)));
        end

        // random sessions, text_left moved every other session
        counting = 1'b1;
        session  = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (session % 2 == 0)
                write_text_left(configs_written <= 5 ? LEFT_PICKS[configs_written - 1] :
                                7'($urandom_range(0, 127)));
            steady_sender = ($urandom_range(0, 3) == 0);
            run_session();
            session++;
        end

        wait_for_results();
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("covered %0d items in %0d sessions over %0d text_left settings, %0d results checked",
                 items_sent, session, configs_written, results_checked);
        $display("longest text %0d characters, deepest scroll offset %0d, %0d mismatches",
                 peak_length, peak_offset, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
design/mqtr_pkg.sv
design/mqtr_glyph.sv
design/marquee_text_column_renderer_top.sv
tb/sv/testbench.sv
